FILE: rtl/core/bma_pkg.sv
// ----------------------------------------------------------------------------
// bma_pkg
// Shared widths, register indexes, reset values, sequencer states and the
// request/response structs of the modulo unit for the battery monitor alarm.
// ----------------------------------------------------------------------------
package bma_pkg;

   localparam int TIME_BITS   = 48;
   localparam int CODE_W      = 16;
   localparam int MV_W        = 15;
   localparam int TEMP_W      = 18;
   localparam int INTERVAL_W  = 24;
   localparam int PERIOD_W    = 16;
   localparam int COUNT_W     = 8;
   localparam int TOTAL_W     = PERIOD_W + COUNT_W;
   localparam int ELAPSED_W   = TOTAL_W;
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_INDEX_W = 3;

   localparam logic signed [TEMP_W-1:0]   FAN_ON_RESET   = 18'sd25000;
   localparam logic [MV_W-1:0]            LOW_MV_RESET   = 15'd7400;
   localparam logic [MV_W-1:0]            MID_MV_RESET   = 15'd7800;
   localparam logic [MV_W-1:0]            HIGH_MV_RESET  = 15'd8200;
   localparam logic [INTERVAL_W-1:0]      INTERVAL_RESET = 24'd30000;
   localparam logic [PERIOD_W-1:0]        BEEP_ON_RESET  = 16'd150;
   localparam logic [PERIOD_W-1:0]        PERIOD_RESET   = 16'd1000;
   localparam logic [COUNT_W-1:0]         COUNT_RESET    = 8'd3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FAN_ON_MILLIDEG  = 3'd0,
      CSR_LOW_MV           = 3'd1,
      CSR_MID_MV           = 3'd2,
      CSR_HIGH_MV          = 3'd3,
      CSR_WARN_INTERVAL_MS = 3'd4,
      CSR_BEEP_ON_MS       = 3'd5,
      CSR_BEEP_PERIOD_MS   = 3'd6,
      CSR_BEEP_COUNT       = 3'd7
   } csr_index_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EVAL  = 6'b000010,
      ST_DIFF  = 6'b000100,
      ST_CHECK = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [ELAPSED_W-1:0] dividend;
      logic [PERIOD_W-1:0]  divisor;
   } mod_req_type;

   typedef struct packed {
      logic                done;
      logic [PERIOD_W-1:0] remainder;
   } mod_rsp_type;

endpackage

FILE: rtl/core/battery_monitor_alarm_core.sv
// ----------------------------------------------------------------------------
// battery_monitor_alarm_core
// Fan, battery LED and warning buzzer control from one sensor sample per item.
// Sequence: accept, evaluate, then output at or above the low threshold; below it,
// the elapsed burst time is taken and checked, and when the phase inside a beep
// period is needed it is taken by a 24-step bit-serial modulo before output.
// One item at a time; the next item is taken the cycle after the result is loaded,
// and an output stall holds the output state until the output is free. Reset
// restores register defaults and clears the burst schedule.
// ----------------------------------------------------------------------------
module battery_monitor_alarm_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [bma_pkg::TIME_BITS-1:0]         req_now_ms,
   input  logic [bma_pkg::CODE_W-1:0]            req_bus_voltage_code,
   input  logic                                  req_voltage_valid,
   input  logic signed [bma_pkg::TEMP_W-1:0]     req_temp_millideg,
   input  logic                                  req_temp_valid,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_fan_on,
   output logic                                  rsp_led_first,
   output logic                                  rsp_led_second,
   output logic                                  rsp_buzzer_on,
   input  logic                                  csr_write_enable,
   input  logic [bma_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [bma_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   logic signed [bma_pkg::TEMP_W-1:0]  fan_on_ff;
   logic [bma_pkg::MV_W-1:0]           low_ff, mid_ff, high_ff;
   logic [bma_pkg::INTERVAL_W-1:0]     interval_ff;
   logic [bma_pkg::PERIOD_W-1:0]       beep_on_ff, period_ff;
   logic [bma_pkg::COUNT_W-1:0]        count_ff;

   bma_pkg::state_type                 state_ff, state_in;
   logic [bma_pkg::TIME_BITS-1:0]      next_warn_ff, next_warn_in;
   logic [bma_pkg::TIME_BITS-1:0]      burst_start_ff, burst_start_in;
   logic [bma_pkg::TIME_BITS-1:0]      now_ff, now_in;
   logic [bma_pkg::TIME_BITS-1:0]      elapsed_ff, elapsed_in;
   logic [bma_pkg::TOTAL_W-1:0]        total_ff, total_in;
   logic [bma_pkg::MV_W-1:0]           mv_ff, mv_in;
   logic signed [bma_pkg::TEMP_W-1:0]  temp_ff, temp_in;
   logic                               low_flag_ff, low_flag_in;
   logic                               fan_ff, fan_in;
   logic                               led1_ff, led1_in;
   logic                               led2_ff, led2_in;
   logic                               buzz_ff, buzz_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_fan_ff, rsp_fan_in;
   logic                               rsp_led1_ff, rsp_led1_in;
   logic                               rsp_led2_ff, rsp_led2_in;
   logic                               rsp_buzz_ff, rsp_buzz_in;

   logic                               req_accept;
   logic                               burst_active;
   logic                               in_range;
   bma_pkg::mod_req_type               mod_req;
   bma_pkg::mod_rsp_type               mod_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         fan_on_ff   <= bma_pkg::FAN_ON_RESET;
         low_ff      <= bma_pkg::LOW_MV_RESET;
         mid_ff      <= bma_pkg::MID_MV_RESET;
         high_ff     <= bma_pkg::HIGH_MV_RESET;
         interval_ff <= bma_pkg::INTERVAL_RESET;
         beep_on_ff  <= bma_pkg::BEEP_ON_RESET;
         period_ff   <= bma_pkg::PERIOD_RESET;
         count_ff    <= bma_pkg::COUNT_RESET;
      end else if (csr_write_enable) begin
         unique case (bma_pkg::csr_index_type'(csr_index))
            bma_pkg::CSR_FAN_ON_MILLIDEG:  fan_on_ff   <= csr_write_data[bma_pkg::TEMP_W-1:0];
            bma_pkg::CSR_LOW_MV:           low_ff      <= csr_write_data[bma_pkg::MV_W-1:0];
            bma_pkg::CSR_MID_MV:           mid_ff      <= csr_write_data[bma_pkg::MV_W-1:0];
            bma_pkg::CSR_HIGH_MV:          high_ff     <= csr_write_data[bma_pkg::MV_W-1:0];
            bma_pkg::CSR_WARN_INTERVAL_MS: interval_ff <= csr_write_data[bma_pkg::INTERVAL_W-1:0];
            bma_pkg::CSR_BEEP_ON_MS:       beep_on_ff  <= csr_write_data[bma_pkg::PERIOD_W-1:0];
            bma_pkg::CSR_BEEP_PERIOD_MS:   period_ff   <= csr_write_data[bma_pkg::PERIOD_W-1:0];
            bma_pkg::CSR_BEEP_COUNT:       count_ff    <= csr_write_data[bma_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall    = (state_ff != bma_pkg::ST_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign burst_active = (burst_start_ff != '0);
   assign in_range     = (elapsed_ff < bma_pkg::TIME_BITS'(total_ff));

   assign mod_req.start    = (state_ff == bma_pkg::ST_CHECK) && burst_active && in_range;
   assign mod_req.dividend = elapsed_ff[bma_pkg::ELAPSED_W-1:0];
   assign mod_req.divisor  = period_ff;

   bma_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .rsp   (mod_rsp)
   );

   always_comb begin
      state_in       = state_ff;
      next_warn_in   = next_warn_ff;
      burst_start_in = burst_start_ff;
      now_in         = now_ff;
      elapsed_in     = elapsed_ff;
      total_in       = total_ff;
      mv_in          = mv_ff;
      temp_in        = temp_ff;
      low_flag_in    = low_flag_ff;
      fan_in         = fan_ff;
      led1_in        = led1_ff;
      led2_in        = led2_ff;
      buzz_in        = buzz_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_fan_in     = rsp_fan_ff;
      rsp_led1_in    = rsp_led1_ff;
      rsp_led2_in    = rsp_led2_ff;
      rsp_buzz_in    = rsp_buzz_ff;

      unique case (state_ff)
         bma_pkg::ST_IDLE: begin
            if (req_accept) begin
               now_in   = req_now_ms;
               mv_in    = req_voltage_valid ? {req_bus_voltage_code[bma_pkg::CODE_W-1:3], 2'b00}
                                            : '0;
               temp_in  = req_temp_valid ? req_temp_millideg : '0;
               state_in = bma_pkg::ST_EVAL;
            end
         end
         bma_pkg::ST_EVAL: begin
            fan_in      = (temp_ff >= fan_on_ff);
            low_flag_in = (mv_ff < low_ff);
            priority if (mv_ff < low_ff) begin
               led1_in = 1'b0;
               led2_in = 1'b0;
            end else if (mv_ff < mid_ff) begin
               led1_in = 1'b0;
               led2_in = 1'b1;
            end else if (mv_ff < high_ff) begin
               led1_in = 1'b1;
               led2_in = 1'b0;
            end else begin
               led1_in = 1'b1;
               led2_in = 1'b1;
            end
            total_in = bma_pkg::TOTAL_W'(period_ff * count_ff);
            buzz_in  = 1'b0;
            if (mv_ff < low_ff) begin
               if (next_warn_ff == '0 || now_ff >= next_warn_ff) begin
                  burst_start_in = now_ff;
                  next_warn_in   = now_ff + bma_pkg::TIME_BITS'(interval_ff);
               end
               state_in = bma_pkg::ST_DIFF;
            end else begin
               next_warn_in   = '0;
               burst_start_in = '0;
               state_in       = bma_pkg::ST_OUT;
            end
         end
         bma_pkg::ST_DIFF: begin
            elapsed_in = now_ff - burst_start_ff;
            state_in   = bma_pkg::ST_CHECK;
         end
         bma_pkg::ST_CHECK: begin
            if (burst_active && in_range) begin
               state_in = bma_pkg::ST_DIV;
            end else begin
               if (burst_active) begin
                  burst_start_in = '0;
               end
               buzz_in  = 1'b0;
               state_in = bma_pkg::ST_OUT;
            end
         end
         bma_pkg::ST_DIV: begin
            if (mod_rsp.done) begin
               buzz_in  = (mod_rsp.remainder < beep_on_ff);
               state_in = bma_pkg::ST_OUT;
            end
         end
         bma_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_fan_in   = fan_ff;
               rsp_led1_in  = led1_ff;
               rsp_led2_in  = led2_ff;
               rsp_buzz_in  = buzz_ff;
               state_in     = bma_pkg::ST_IDLE;
            end
         end
         default: state_in = bma_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bma_pkg::ST_IDLE;
         next_warn_ff   <= '0;
         burst_start_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         next_warn_ff   <= next_warn_in;
         burst_start_ff <= burst_start_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      now_ff      <= now_in;
      elapsed_ff  <= elapsed_in;
      total_ff    <= total_in;
      mv_ff       <= mv_in;
      temp_ff     <= temp_in;
      low_flag_ff <= low_flag_in;
      fan_ff      <= fan_in;
      led1_ff     <= led1_in;
      led2_ff     <= led2_in;
      buzz_ff     <= buzz_in;
      rsp_fan_ff  <= rsp_fan_in;
      rsp_led1_ff <= rsp_led1_in;
      rsp_led2_ff <= rsp_led2_in;
      rsp_buzz_ff <= rsp_buzz_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fan_on     = rsp_fan_ff;
   assign rsp_led_first  = rsp_led1_ff;
   assign rsp_led_second = rsp_led2_ff;
   assign rsp_buzzer_on  = rsp_buzz_ff;

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      mod_req.start |-> (period_ff != '0) && (count_ff != '0))
      else $error("modulo started with an empty burst length");

   a_clear_when_high: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bma_pkg::ST_EVAL) && !(mv_ff < low_ff)
      |=> (burst_start_ff == '0) && (next_warn_ff == '0))
      else $error("burst state not cleared above low threshold");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == bma_pkg::ST_OUT))
      else $error("result loaded outside output state");

   a_div_low_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bma_pkg::ST_DIV) |-> low_flag_ff)
      else $error("beep phase taken for a sample above low threshold");

endmodule

FILE: rtl/core/bma_mod_unit.sv
// ----------------------------------------------------------------------------
// bma_mod_unit
// Bit-serial restoring modulo: one dividend bit per cycle, remainder valid
// with a one-cycle done pulse after ELAPSED_W steps. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module bma_mod_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  bma_pkg::mod_req_type req,
   output bma_pkg::mod_rsp_type rsp
);

   localparam int CNT_W = $clog2(bma_pkg::ELAPSED_W + 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [bma_pkg::ELAPSED_W-1:0] quo_ff, quo_in;
   logic [bma_pkg::PERIOD_W-1:0]  rem_ff, rem_in;
   logic [bma_pkg::PERIOD_W-1:0]  divisor_ff, divisor_in;
   logic [bma_pkg::PERIOD_W:0]    shifted;

   assign shifted = {rem_ff, quo_ff[bma_pkg::ELAPSED_W-1]};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (req.start) begin
         busy_in    = 1'b1;
         cnt_in     = CNT_W'(bma_pkg::ELAPSED_W);
         quo_in     = req.dividend;
         rem_in     = '0;
         divisor_in = req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[bma_pkg::ELAPSED_W-2:0], 1'b0};
         if (shifted >= {1'b0, divisor_ff}) begin
            rem_in = bma_pkg::PERIOD_W'(shifted - {1'b0, divisor_ff});
         end else begin
            rem_in = shifted[bma_pkg::PERIOD_W-1:0];
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule
